[rtl/salru_pkg.sv]
package salru_pkg;

	localparam int DEF_MAX_SET_BITS = 8;
	localparam int DEF_MAX_WAYS     = 8;
	localparam int TAG_W            = 64;
	localparam int FIFO_DEPTH       = 2;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_STORE  = 2'd1,
		FUNC_MODIFY = 2'd2,
		FUNC_SPARE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_SET_BITS   = 2'd0,
		REG_WAYS       = 2'd1,
		REG_BLOCK_BITS = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

endpackage

[rtl/salru_ram.sv]
module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/salru_fifo.sv]
module salru_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	// depth is a power of two so the pointers wrap on their own
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign full     = (count_q == CntW'(DEPTH));
	assign empty    = (count_q == '0);

endmodule

[rtl/salru_front.sv]
module salru_front #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ENT_W        = 77
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           func,
	input  logic [63:0]          address,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [5:0]           cfg_data,
	input  logic                 full,
	input  logic                 clearing,
	output logic                 busy,
	output logic                 push,
	output logic [ENT_W-1:0]     push_data
);

	import salru_pkg::*;

	localparam int IdxW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WayCntW = $clog2(MAX_WAYS + 1);

	logic [3:0]         set_bits_q;
	logic [3:0]         ways_q;
	logic [5:0]         block_bits_q;
	logic [3:0]         set_eff;
	logic [4:0]         ways_wide;
	logic [WayCntW-1:0] ways_eff;
	logic [6:0]         tag_shift;
	logic [63:0]        shifted;
	logic [TAG_W-1:0]   tag;
	logic [IdxW-1:0]    idx;
	logic               dual;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 4'd0;
			ways_q       <= 4'd1;
			block_bits_q <= 6'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				REG_WAYS:       ways_q       <= cfg_data[3:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		set_eff = (set_bits_q > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_q;
		ways_wide = {1'b0, ways_q};
		if (ways_wide == 5'd0) begin
			ways_eff = WayCntW'(1);
		end else if (ways_wide > 5'(MAX_WAYS)) begin
			ways_eff = WayCntW'(MAX_WAYS);
		end else begin
			ways_eff = WayCntW'(ways_wide);
		end
		tag_shift = 7'(set_eff) + 7'(block_bits_q);
		// offset and index together can cover the whole address
		tag = tag_shift[6] ? '0 : (address >> tag_shift[5:0]);
		shifted = address >> block_bits_q;
		for (int i = 0; i < IdxW; i++) begin
			idx[i] = shifted[i] && (i < int'(set_eff));
		end
		dual = (func == FUNC_MODIFY);
	end

	assign busy      = clearing | full;
	assign push      = start & ~busy;
	assign push_data = {dual, ways_eff, tag, idx};

endmodule

[rtl/salru_back.sv]
module salru_back #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ENT_W        = 77
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  logic [ENT_W-1:0] pop_data,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output logic             hit,
	output logic             miss,
	output logic             evicted,
	output logic             last,
	output logic [31:0]      total_hits,
	output logic [31:0]      total_misses,
	output logic [31:0]      total_evictions
);

	import salru_pkg::*;

	localparam int IdxW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WayCntW = $clog2(MAX_WAYS + 1);
	localparam int WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AgeW    = WayW;
	localparam int RowW    = MAX_WAYS * (1 + TAG_W + AgeW);
	localparam int Rows    = 1 << IdxW;
	localparam logic [AgeW-1:0] AgeMax = AgeW'(MAX_WAYS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_LOOK   = 4'b0100,
		ST_SECOND = 4'b1000
	} back_state_t;

	back_state_t state_q;
	logic [IdxW-1:0]    clr_q;
	logic [IdxW-1:0]    idx_q;
	logic [TAG_W-1:0]   tag_q;
	logic [WayCntW-1:0] ways_q;
	logic               dual_q;

	logic                  ram_we;
	logic [IdxW-1:0]       ram_waddr;
	logic [RowW-1:0]       ram_wdata;
	logic [RowW-1:0]       ram_rdata;

	logic [MAX_WAYS-1:0]             rv;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  rt;
	logic [MAX_WAYS-1:0][AgeW-1:0]   ra;
	logic [MAX_WAYS-1:0]             nv;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  nt;
	logic [MAX_WAYS-1:0][AgeW-1:0]   na;
	logic [MAX_WAYS-1:0]             lane_en;
	logic [MAX_WAYS-1:0]             match;
	logic [MAX_WAYS-1:0]             inval;
	logic [WayW-1:0]                 hit_way;
	logic [WayW-1:0]                 inv_way;
	logic [WayW-1:0]                 lru_way;
	logic [WayW-1:0]                 victim;
	logic [AgeW-1:0]                 best;
	logic [AgeW-1:0]                 ref_age;
	logic                            lk_hit;
	logic                            lk_evict;

	logic        done_q, hit_q, miss_q, evicted_q, last_q;
	logic [31:0] hits_q, misses_q, evicts_q;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	salru_ram #(
		.WIDTH(RowW),
		.DEPTH(Rows)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop),
		.raddr(pop_data[IdxW-1:0]),
		.rdata(ram_rdata)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !empty;

	assign rv = ram_rdata[RowW-1 -: MAX_WAYS];
	assign rt = ram_rdata[MAX_WAYS*AgeW +: MAX_WAYS*TAG_W];
	assign ra = ram_rdata[MAX_WAYS*AgeW-1:0];

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			lane_en[w] = WayCntW'(w) < ways_q;
			match[w]   = lane_en[w] && rv[w] && (rt[w] == tag_q);
			inval[w]   = lane_en[w] && !rv[w];
		end
		hit_way = '0;
		inv_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) hit_way = WayW'(w);
			if (inval[w]) inv_way = WayW'(w);
		end
		// oldest way wins, lowest way on a tie
		best    = '0;
		lru_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (lane_en[w] && ra[w] > best) begin
				best    = ra[w];
				lru_way = WayW'(w);
			end
		end
		lk_hit   = |match;
		lk_evict = !lk_hit && !(|inval);
		if (lk_hit) begin
			victim = hit_way;
		end else if (|inval) begin
			victim = inv_way;
		end else begin
			victim = lru_way;
		end
		ref_age = ra[hit_way];
		for (int w = 0; w < MAX_WAYS; w++) begin
			nv[w] = rv[w];
			nt[w] = rt[w];
			na[w] = ra[w];
			if (WayW'(w) == victim) begin
				nv[w] = 1'b1;
				nt[w] = tag_q;
				na[w] = '0;
			end else if (lane_en[w] && rv[w] && ra[w] < AgeMax
					&& (!lk_hit || ra[w] < ref_age)) begin
				na[w] = ra[w] + AgeW'(1);
			end
		end
	end

	always_comb begin
		ram_we    = clearing || (state_q == ST_LOOK);
		ram_waddr = clearing ? clr_q : idx_q;
		ram_wdata = clearing ? '0 : {nv, nt, na};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q  <= pop_data[IdxW-1:0];
			tag_q  <= pop_data[IdxW +: TAG_W];
			ways_q <= pop_data[IdxW+TAG_W +: WayCntW];
			dual_q <= pop_data[ENT_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			miss_q    <= 1'b0;
			evicted_q <= 1'b0;
			last_q    <= 1'b0;
			hits_q    <= '0;
			misses_q  <= '0;
			evicts_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IdxW'(1);
					if (clr_q == IdxW'(Rows - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!empty) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					done_q    <= 1'b1;
					hit_q     <= lk_hit;
					miss_q    <= !lk_hit;
					evicted_q <= lk_evict;
					last_q    <= !dual_q;
					if (lk_hit) begin
						hits_q <= sat_inc(hits_q);
					end else begin
						misses_q <= sat_inc(misses_q);
					end
					if (lk_evict) begin
						evicts_q <= sat_inc(evicts_q);
					end
					state_q <= dual_q ? ST_SECOND : ST_IDLE;
				end
				ST_SECOND: begin
					// line was just made most recent, so the set is left as is
					done_q    <= 1'b1;
					hit_q     <= 1'b1;
					miss_q    <= 1'b0;
					evicted_q <= 1'b0;
					last_q    <= 1'b1;
					hits_q    <= sat_inc(hits_q);
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done            = done_q;
	assign hit             = hit_q;
	assign miss            = miss_q;
	assign evicted         = evicted_q;
	assign last            = last_q;
	assign total_hits      = hits_q;
	assign total_misses    = misses_q;
	assign total_evictions = evicts_q;

endmodule

[rtl/set_assoc_cache_hit_miss_lru.sv]
// a modify word gives two results, every other word one; the back end handles a lookup
// in two steps (set read from the tag ram, then compare, lru update and write-back),
// and a modify adds a third step for its second result.
// a two-word queue decouples start from the back end; busy rises when it is full.
// after reset the tag ram is swept clear row by row, with busy high.
// results are shown for one cycle on done; the receiver cannot stall.
module set_assoc_cache_hit_miss_lru #(
	parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [63:0] address,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	output logic        done,
	output logic        hit,
	output logic        miss,
	output logic        evicted,
	output logic        last,
	output logic [31:0] total_hits,
	output logic [31:0] total_misses,
	output logic [31:0] total_evictions
);

	import salru_pkg::*;

	localparam int IdxW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WayCntW = $clog2(MAX_WAYS + 1);
	localparam int EntW    = 1 + WayCntW + TAG_W + IdxW;

	logic            push;
	logic [EntW-1:0] push_data;
	logic            pop;
	logic [EntW-1:0] pop_data;
	logic            full;
	logic            empty;
	logic            clearing;

	salru_front #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS),
		.ENT_W       (EntW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.func     (func),
		.address  (address),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.full     (full),
		.clearing (clearing),
		.busy     (busy),
		.push     (push),
		.push_data(push_data)
	);

	salru_fifo #(
		.WIDTH(EntW),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (full),
		.empty    (empty)
	);

	salru_back #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS),
		.ENT_W       (EntW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.pop_data       (pop_data),
		.pop            (pop),
		.clearing       (clearing),
		.done           (done),
		.hit            (hit),
		.miss           (miss),
		.evicted        (evicted),
		.last           (last),
		.total_hits     (total_hits),
		.total_misses   (total_misses),
		.total_evictions(total_evictions)
	);

endmodule

[rtl/salru_checker.sv]
module salru_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic        hit,
	input logic        miss,
	input logic        evicted,
	input logic        last,
	input logic [31:0] total_hits,
	input logic [31:0] total_misses,
	input logic [31:0] total_evictions
);

	a_hit_xor_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit != miss))
		else $error("hit and miss not exclusive");

	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> miss)
		else $error("eviction without miss");

	// second lookup of a modify follows at once and always hits
	a_modify_second: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done && last && hit)
		else $error("modify second word missing or not a hit");

	a_hit_totals: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> total_misses == $past(total_misses)
			&& total_evictions == $past(total_evictions))
		else $error("miss or eviction total moved on a hit");

endmodule

bind set_assoc_cache_hit_miss_lru salru_checker u_salru_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

	import salru_pkg::*;

	localparam int NUM_LINES       = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
	localparam int AGE_MAX         = DEF_MAX_WAYS - 1;
	localparam int NUM_PHASES      = 12;
	localparam int WORDS_PER_PHASE = 160;
	localparam int DRAIN_PAUSE     = 8;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int MAX_TAGS        = 12;

	typedef struct packed {
		logic        is_hit;
		logic        is_miss;
		logic        is_evict;
		logic        is_last;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evicts;
	} lookup_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [63:0] address;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;
	logic        done;
	logic        hit;
	logic        miss;
	logic        evicted;
	logic        last;
	logic [31:0] total_hits;
	logic [31:0] total_misses;
	logic [31:0] total_evictions;

	// shadow of the tag store
	logic        line_ok  [NUM_LINES];
	logic [63:0] line_key [NUM_LINES];
	logic [2:0]  line_lru [NUM_LINES];
	logic [31:0] hits_sum;
	logic [31:0] misses_sum;
	logic [31:0] evicts_sum;
	logic [3:0]  geo_set_bits;
	logic [3:0]  geo_ways;
	logic [5:0]  geo_block_bits;

	lookup_res_t pending_lookups[$];
	int          mismatches;
	int          quiet_cycles;

	set_assoc_cache_hit_miss_lru dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int eff_set_bits();
		return (geo_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(geo_set_bits);
	endfunction

	function automatic int eff_ways();
		if (geo_ways == 0)
			return 1;
		return (geo_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(geo_ways);
	endfunction

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// age the other valid ways of a set; on a hit only those younger than the hit line
	function automatic void age_others(int base, int ways, int skip, bit limit,
			logic [2:0] below);
		for (int w = 0; w < ways; w++) begin
			if (w != skip && line_ok[base + w] && !(limit && line_lru[base + w] >= below)
					&& line_lru[base + w] < AGE_MAX)
				line_lru[base + w] = line_lru[base + w] + 3'd1;
		end
	endfunction

	function automatic lookup_res_t cache_lookup(logic [63:0] addr, logic is_last);
		int          s;
		int          e;
		int          b;
		int          base;
		int          victim;
		logic [63:0] key;
		logic [2:0]  oldest;
		lookup_res_t r;
		s = eff_set_bits();
		e = eff_ways();
		b = int'(geo_block_bits);
		key = (s + b < 64) ? (addr >> (s + b)) : 64'd0;
		base = int'((addr >> b) & ((64'd1 << s) - 64'd1)) * DEF_MAX_WAYS;
		r = '0;
		r.is_last = is_last;
		for (int w = 0; w < e; w++) begin
			if (line_ok[base + w] && line_key[base + w] == key) begin
				age_others(base, e, w, 1'b1, line_lru[base + w]);
				line_lru[base + w] = 3'd0;
				r.is_hit = 1'b1;
				break;
			end
		end
		if (r.is_hit) begin
			hits_sum = sat_inc(hits_sum);
		end else begin
			r.is_miss = 1'b1;
			misses_sum = sat_inc(misses_sum);
			victim = -1;
			for (int w = 0; w < e; w++) begin
				if (!line_ok[base + w]) begin
					victim = w;
					break;
				end
			end
			if (victim < 0) begin
				// lowest way wins among equally old lines
				victim = 0;
				oldest = 3'd0;
				for (int w = 0; w < e; w++) begin
					if (line_lru[base + w] > oldest) begin
						oldest = line_lru[base + w];
						victim = w;
					end
				end
				r.is_evict = 1'b1;
				evicts_sum = sat_inc(evicts_sum);
			end
			age_others(base, e, victim, 1'b0, 3'd0);
			line_ok[base + victim] = 1'b1;
			line_key[base + victim] = key;
			line_lru[base + victim] = 3'd0;
		end
		r.hits = hits_sum;
		r.misses = misses_sum;
		r.evicts = evicts_sum;
		return r;
	endfunction

	// address that lands on a given tag and set under the current geometry
	function automatic logic [63:0] make_addr(logic [63:0] key, logic [63:0] set_no,
			logic [63:0] offset);
		int          s;
		int          b;
		logic [63:0] low_mask;
		logic [63:0] set_mask;
		s = eff_set_bits();
		b = int'(geo_block_bits);
		low_mask = (64'd1 << b) - 64'd1;
		set_mask = ((64'd1 << s) - 64'd1) << b;
		return ((s + b < 64) ? (key << (s + b)) : 64'd0) | ((set_no << b) & set_mask)
			| (offset & low_mask);
	endfunction

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, actual %0h", name, want, got);
		end
	endfunction

	task automatic send_access(func_t f, logic [63:0] a, bit steady);
		int gap;
		start <= 1'b1;
		func <= f;
		address <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (f == FUNC_MODIFY) begin
			pending_lookups.push_back(cache_lookup(a, 1'b0));
			pending_lookups.push_back(cache_lookup(a, 1'b1));
		end else begin
			pending_lookups.push_back(cache_lookup(a, 1'b1));
		end
		gap = steady ? 0 : gap_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// spare upper data bits are random, the block must drop them
	task automatic configure_cache(logic [3:0] sb, logic [3:0] wy, logic [5:0] bb);
		logic [31:0] junk;
		wait_idle();
		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= REG_SET_BITS;
		cfg_data <= {junk[1:0], sb};
		@(posedge clk);
		cfg_index <= REG_WAYS;
		cfg_data <= {junk[3:2], wy};
		@(posedge clk);
		cfg_index <= REG_BLOCK_BITS;
		cfg_data <= bb;
		@(posedge clk);
		cfg_index <= REG_NONE;
		cfg_data <= junk[9:4];
		@(posedge clk);
		cfg_we <= 1'b0;
		geo_set_bits = sb;
		geo_ways = wy;
		geo_block_bits = bb;
	endtask

	task automatic test_reset_geometry();
		send_access(FUNC_LOAD, 64'd0, 1'b0);
		send_access(FUNC_STORE, '1, 1'b0);
		send_access(FUNC_MODIFY, 64'h8000_0000_0000_0000, 1'b0);
		send_access(FUNC_SPARE, 64'h5555_5555_AAAA_AAAA, 1'b0);
		send_access(FUNC_LOAD, 64'h5555_5555_AAAA_AAAA, 1'b0);
		send_access(FUNC_MODIFY, '1, 1'b0);
	endtask

	task automatic test_lru_order();
		configure_cache(4'd1, 4'd4, 6'd3);
		for (int t = 1; t <= 4; t++)
			send_access(FUNC_LOAD, make_addr(64'(t), 64'd1, 64'd5), 1'b0);
		send_access(FUNC_LOAD, make_addr(64'd1, 64'd1, 64'd0), 1'b0);
		send_access(FUNC_STORE, make_addr(64'd5, 64'd1, 64'd7), 1'b0);
		send_access(FUNC_MODIFY, make_addr(64'd2, 64'd1, 64'd1), 1'b0);
		// shrink then regrow the set so that line ages tie
		configure_cache(4'd1, 4'd2, 6'd3);
		send_access(FUNC_LOAD, make_addr(64'd6, 64'd1, 64'd0), 1'b0);
		send_access(FUNC_STORE, make_addr(64'd7, 64'd1, 64'd0), 1'b0);
		configure_cache(4'd1, 4'd4, 6'd3);
		for (int t = 8; t <= 10; t++)
			send_access(FUNC_LOAD, make_addr(64'(t), 64'd1, 64'd2), 1'b0);
		send_access(FUNC_MODIFY, make_addr(64'd6, 64'd1, 64'd3), 1'b0);
	endtask

	task automatic test_wide_offset();
		// offset plus index covers the whole address: every tag is zero
		configure_cache(4'd8, 4'd0, 6'd56);
		send_access(FUNC_LOAD, 64'h00AB_0000_1234_5678, 1'b0);
		send_access(FUNC_STORE, 64'h00AB_FFFF_0000_0000, 1'b0);
		send_access(FUNC_LOAD, '1, 1'b0);
		configure_cache(4'd15, 4'd15, 6'd63);
		send_access(FUNC_LOAD, 64'd0, 1'b0);
		send_access(FUNC_MODIFY, 64'h8000_0000_0000_0001, 1'b0);
		send_access(FUNC_LOAD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [63:0] tag_pool [MAX_TAGS];
		logic [63:0] set_pool [3];
		logic [3:0]  sb;
		logic [3:0]  wy;
		logic [5:0]  bb;
		logic [63:0] a;
		int          n_tags;
		bit          steady;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					sb = 4'd8; wy = 4'd8; bb = 6'd0;
				end
				1: begin
					sb = 4'd0; wy = 4'd1; bb = 6'd32;
				end
				2: begin
					sb = 4'd15; wy = 4'd15; bb = 6'd63;
				end
				3: begin
					sb = 4'd2; wy = 4'd0; bb = 6'd5;
				end
				default: begin
					sb = 4'($urandom_range(0, 15));
					wy = 4'($urandom_range(0, 15));
					bb = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 32))
						: 6'($urandom_range(33, 63));
				end
			endcase
			configure_cache(sb, wy, bb);
			// small tag and set numbers recur across phases, so old lines get hit again
			n_tags = eff_ways() + $urandom_range(1, 3);
			for (int k = 0; k < MAX_TAGS; k++)
				tag_pool[k] = $urandom_range(0, 1) ? 64'($urandom_range(0, 15))
					: {$urandom, $urandom};
			for (int k = 0; k < 3; k++)
				set_pool[k] = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
					: 64'($urandom_range(0, 3));
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if ($urandom_range(0, 99) < 85)
					a = make_addr(tag_pool[$urandom_range(0, n_tags - 1)],
						set_pool[$urandom_range(0, 2)], {$urandom, $urandom});
				else
					a = {$urandom, $urandom};
				send_access(func_t'($urandom_range(0, 3)), a, steady);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		lookup_res_t want;
		if (arst_n && done) begin
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with no lookup pending");
			end else begin
				want = pending_lookups.pop_front();
				check_field("hit", 32'(hit), 32'(want.is_hit));
				check_field("miss", 32'(miss), 32'(want.is_miss));
				check_field("evicted", 32'(evicted), 32'(want.is_evict));
				check_field("last", 32'(last), 32'(want.is_last));
				check_field("total_hits", total_hits, want.hits);
				check_field("total_misses", total_misses, want.misses);
				check_field("total_evictions", total_evictions, want.evicts);
			end
		end
	end

	// covers the clearing sweep after reset too
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_LOAD;
		address = 64'd0;
		cfg_we = 1'b0;
		cfg_index = REG_SET_BITS;
		cfg_data = 6'd0;
		mismatches = 0;
		for (int k = 0; k < NUM_LINES; k++) begin
			line_ok[k] = 1'b0;
			line_key[k] = 64'd0;
			line_lru[k] = 3'd0;
		end
		hits_sum = 32'd0;
		misses_sum = 32'd0;
		evicts_sum = 32'd0;
		geo_set_bits = 4'd0;
		geo_ways = 4'd1;
		geo_block_bits = 6'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		test_reset_geometry();
		test_lru_order();
		test_wide_offset();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/salru_pkg.sv
rtl/salru_ram.sv
rtl/salru_fifo.sv
rtl/salru_front.sv
rtl/salru_back.sv
rtl/set_assoc_cache_hit_miss_lru.sv
rtl/salru_checker.sv
tb/sv/tb.sv
